@@ sv/qsed_pkg.sv @@
// Package with the shared types, codes and constants of the quadrature step event detector.
`default_nettype none

package qsed_pkg;

   localparam int TIMESTAMP_WIDTH = 32;
   localparam int THRESHOLD_WIDTH = 6;
   localparam int SUM_WIDTH       = 8;
   localparam int POSITION_WIDTH  = 16;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [TIMESTAMP_WIDTH-1:0] TIMEOUT_RESET   = 32'd500000;
   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 6'd2;

   typedef enum logic [0:0] {
      CSR_TIMEOUT   = 1'b0,
      CSR_THRESHOLD = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_RIGHT = 2'd1,
      EVT_LEFT  = 2'd2
   } event_type;

   // Step for the old pin pair in the upper two bits and the new pair in the lower two.
   localparam logic signed [1:0] STEP_TABLE [16] = '{
      2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
      -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
   };

   typedef struct packed {
      logic [1:0]                        last_pins;
      logic signed [SUM_WIDTH-1:0]       step_sum;
      logic [TIMESTAMP_WIDTH-1:0]        last_tick;
      logic signed [POSITION_WIDTH-1:0]  detent_count;
   } state_type;

   typedef struct packed {
      event_type                         event_res;
      logic [TIMESTAMP_WIDTH-1:0]        elapsed_us;
      logic signed [POSITION_WIDTH-1:0]  position;
   } result_type;

endpackage

`default_nettype wire

@@ sv/qsed_if.sv @@
// Request and response channel interfaces of the quadrature step event detector.
`default_nettype none

interface qsed_req_if
   import qsed_pkg::*;
   ;
   logic                        valid;
   logic                        ready;
   logic                        pin_a;
   logic                        pin_b;
   logic [TIMESTAMP_WIDTH-1:0]  timestamp_us;

   modport source (output valid, output pin_a, output pin_b, output timestamp_us,
                   input ready);
   modport sink (input valid, input pin_a, input pin_b, input timestamp_us,
                 output ready);
endinterface

interface qsed_rsp_if
   import qsed_pkg::*;
   ;
   logic                              valid;
   logic                              ready;
   event_type                         event_res;
   logic [TIMESTAMP_WIDTH-1:0]        elapsed_us;
   logic signed [POSITION_WIDTH-1:0]  position;

   modport source (output valid, output event_res, output elapsed_us, output position,
                   input ready);
   modport sink (input valid, input event_res, input elapsed_us, input position,
                 output ready);
endinterface

`default_nettype wire

@@ sv/quadrature_step_event_detector_core.sv @@
// Top level of the quadrature step event detector with input, state and result registers.
`default_nettype none

// The block takes one request per clock while its responses are taken, and returns one
// response for each. An accepted request is captured in the input register and then moves
// on to the result register, where its response is valid. The table lookup, accumulation,
// timeout and threshold checks run between the input register and the result register,
// where the encoder state is updated as well. The result register lets one more request
// enter while a finished response waits; the input stalls only when both registers are
// full and the response is not taken. Configuration writes are meant for idle periods
// only.
module quadrature_step_event_detector_core
   import qsed_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   qsed_req_if.sink                    req,
   qsed_rsp_if.source                  rsp,
   input  logic                        csr_we,
   input  csr_index_type               csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic                          s1_valid_ff;
   logic                          s1_pin_a_ff;
   logic                          s1_pin_b_ff;
   logic [TIMESTAMP_WIDTH-1:0]    s1_ts_ff;
   logic                          rsp_valid_ff;
   result_type                    rsp_result_ff;
   state_type                     state_ff;
   state_type                     state_in;
   result_type                    result_in;
   logic [TIMESTAMP_WIDTH-1:0]    timeout_ff;
   logic [THRESHOLD_WIDTH-1:0]    threshold_ff;
   logic                          out_free;
   logic                          s1_advance;
   logic                          req_take;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req.ready  = !s1_valid_ff || out_free;
   assign req_take   = req.valid && req.ready;

   qsed_eval u_eval (
      .state_cur      (state_ff),
      .pin_a          (s1_pin_a_ff),
      .pin_b          (s1_pin_b_ff),
      .timestamp_us   (s1_ts_ff),
      .timeout_us     (timeout_ff),
      .step_threshold (threshold_ff),
      .state_next     (state_in),
      .result         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         if (req.ready) begin
            s1_valid_ff <= req.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_advance) begin
            state_ff <= state_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT: begin
                  timeout_ff <= csr_wdata[TIMESTAMP_WIDTH-1:0];
               end
               CSR_THRESHOLD: begin
                  threshold_ff <= csr_wdata[THRESHOLD_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pin_a_ff <= req.pin_a;
         s1_pin_b_ff <= req.pin_b;
         s1_ts_ff    <= req.timestamp_us;
      end
      if (s1_advance) begin
         rsp_result_ff <= result_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_res  = rsp_result_ff.event_res;
   assign rsp.elapsed_us = rsp_result_ff.elapsed_us;
   assign rsp.position   = rsp_result_ff.position;

`ifndef SYNTH
   // A fired event always clears the step accumulator.
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && result_in.event_res != EVT_NONE) |=> state_ff.step_sum == '0)
      else $error("step accumulator not cleared after an event");

   // A response without an event carries no elapsed time.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_result_ff.event_res == EVT_NONE) |-> rsp_result_ff.elapsed_us == '0)
      else $error("elapsed time set on a response without an event");

   // The reported position is the state left behind by that request.
   assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_result_ff.position == state_ff.detent_count)
      else $error("response position differs from the stored detent count");
`endif

endmodule

`default_nettype wire

@@ sv/qsed_eval.sv @@
// Step lookup, accumulation, timeout and threshold checks for one pin sample.
`default_nettype none

module qsed_eval
   import qsed_pkg::*;
(
   input  state_type                    state_cur,
   input  logic                         pin_a,
   input  logic                         pin_b,
   input  logic [TIMESTAMP_WIDTH-1:0]   timestamp_us,
   input  logic [TIMESTAMP_WIDTH-1:0]   timeout_us,
   input  logic [THRESHOLD_WIDTH-1:0]   step_threshold,
   output state_type                    state_next,
   output result_type                   result
);

   logic [1:0]                    pair;
   logic signed [1:0]             step;
   logic signed [SUM_WIDTH-1:0]   sum_new;
   logic signed [SUM_WIDTH-1:0]   thr_pos;
   logic signed [SUM_WIDTH-1:0]   thr_neg;
   logic [TIMESTAMP_WIDTH-1:0]    dt;

   assign pair    = {pin_b, pin_a};
   assign step    = STEP_TABLE[{state_cur.last_pins, pair}];
   assign sum_new = state_cur.step_sum + {{(SUM_WIDTH-2){step[1]}}, step};
   assign thr_pos = {{(SUM_WIDTH-THRESHOLD_WIDTH){1'b0}}, step_threshold};
   assign thr_neg = -thr_pos;
   assign dt      = timestamp_us - state_cur.last_tick;

   always_comb begin
      state_next              = state_cur;
      state_next.last_pins    = pair;
      state_next.step_sum     = sum_new;
      result.event_res        = EVT_NONE;
      result.elapsed_us       = '0;
      if (dt > timeout_us) begin
         state_next.step_sum  = '0;
         state_next.last_pins = '0;
         state_next.last_tick = timestamp_us;
      end else if (sum_new > thr_pos) begin
         state_next.detent_count = state_cur.detent_count + 16'sd1;
         state_next.step_sum     = '0;
         state_next.last_tick    = timestamp_us;
         result.event_res        = EVT_RIGHT;
         result.elapsed_us       = dt;
      end else if (sum_new < thr_neg) begin
         state_next.detent_count = state_cur.detent_count - 16'sd1;
         state_next.step_sum     = '0;
         state_next.last_tick    = timestamp_us;
         result.event_res        = EVT_LEFT;
         result.elapsed_us       = dt;
      end
      result.position = state_next.detent_count;
   end

endmodule

`default_nettype wire
